[sv/framebuffer_draw_engine_top_assert.svh]
// ----------------------------------------------------------------------------
// framebuffer draw engine assertion macros
// implication and next-cycle checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_DRAW_ENGINE_TOP_ASSERT_SVH
`define FRAMEBUFFER_DRAW_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define FDE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fde same-cycle check failed");

// next-cycle implication
`define FDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fde next-cycle check failed");

`else

`define FDE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[sv/fde_pkg.sv]
// ----------------------------------------------------------------------------
// fde_pkg
// shared types and constants of the framebuffer draw engine
// ----------------------------------------------------------------------------
`default_nettype none

package fde_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = X_W + Y_W;
	localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;

	localparam int SIZE_W     = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;

	localparam logic [2:0] MODE_PIXEL = 3'd0;
	localparam logic [2:0] MODE_FILL  = 3'd1;
	localparam logic [2:0] MODE_LINE  = 3'd2;
	localparam logic [2:0] MODE_RECT  = 3'd3;
	localparam logic [2:0] MODE_DISK  = 3'd4;
	localparam logic [2:0] MODE_READ  = 3'd5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] first_x;
		logic [7:0] first_y;
		logic [7:0] second_x;
		logic [7:0] second_y;
		logic [7:0] disk_radius;
		logic [7:0] pixel_value;
	} cmd_in_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       coord_error;
	} result_t;

	// back-end operations
	typedef enum logic [2:0] {
		OP_NOP     = 3'd0,
		OP_BOX     = 3'd1,
		OP_OUTLINE = 3'd2,
		OP_DISK    = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef struct packed {
		op_t            op;
		logic           err;
		logic [7:0]     value;
		logic [X_W-1:0] x_lo;
		logic [X_W-1:0] x_hi;
		logic [Y_W-1:0] y_lo;
		logic [Y_W-1:0] y_hi;
		logic [X_W-1:0] cx;
		logic [Y_W-1:0] cy;
		logic [15:0]    rr;
		logic [16:0]    dx2_init;
		logic [16:0]    dy2_init;
	} cmd_t;

endpackage

`default_nettype wire

[sv/fde_front.sv]
// ----------------------------------------------------------------------------
// fde_front
// config registers, command accept and classification into back-end ops
// ----------------------------------------------------------------------------
`default_nettype none

module fde_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fde_pkg::SIZE_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire fde_pkg::cmd_in_t               in_data,
	input  wire logic                           q_full,
	input  wire logic                           clearing,
	output logic                                push,
	output fde_pkg::cmd_t                       push_cmd
);

	logic [fde_pkg::SIZE_W-1:0] width_q;
	logic [fde_pkg::SIZE_W-1:0] height_q;

	logic       in1, in2, area_ok, axis_ok;
	logic [7:0] x_lim, y_lim;
	logic [7:0] x_min, x_max, y_min, y_max;
	logic [7:0] xs, ys, xe, ye, dmx, dmy;
	logic [8:0] xe9, ye9;
	logic [15:0] dx2, dy2, rr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_valid) begin
			if (cfg_index == fde_pkg::CFG_ACTIVE_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == fde_pkg::CFG_ACTIVE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign in_stall = q_full | clearing;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		in1 = ({1'b0, in_data.first_x} < width_q) && ({1'b0, in_data.first_y} < height_q);
		in2 = ({1'b0, in_data.second_x} < width_q) && ({1'b0, in_data.second_y} < height_q);
		area_ok = (width_q != '0) && (height_q != '0);
		axis_ok = (in_data.first_x == in_data.second_x) || (in_data.first_y == in_data.second_y);

		// last usable column and row, sizes above the frame act as the frame
		x_lim = width_q[8]  ? 8'hFF : 8'(width_q[7:0] - 8'd1);
		y_lim = height_q[8] ? 8'hFF : 8'(height_q[7:0] - 8'd1);

		x_min = (in_data.first_x < in_data.second_x) ? in_data.first_x : in_data.second_x;
		x_max = (in_data.first_x < in_data.second_x) ? in_data.second_x : in_data.first_x;
		y_min = (in_data.first_y < in_data.second_y) ? in_data.first_y : in_data.second_y;
		y_max = (in_data.first_y < in_data.second_y) ? in_data.second_y : in_data.first_y;

		// clipped disk bounding box
		xs  = (in_data.first_x > in_data.disk_radius) ?
			8'(in_data.first_x - in_data.disk_radius) : 8'd0;
		ys  = (in_data.first_y > in_data.disk_radius) ?
			8'(in_data.first_y - in_data.disk_radius) : 8'd0;
		xe9 = {1'b0, in_data.first_x} + {1'b0, in_data.disk_radius};
		ye9 = {1'b0, in_data.first_y} + {1'b0, in_data.disk_radius};
		xe  = (xe9 > {1'b0, x_lim}) ? x_lim : xe9[7:0];
		ye  = (ye9 > {1'b0, y_lim}) ? y_lim : ye9[7:0];

		// squared distance at the box corner, offset is min(center, radius)
		dmx = (in_data.first_x < in_data.disk_radius) ? in_data.first_x : in_data.disk_radius;
		dmy = (in_data.first_y < in_data.disk_radius) ? in_data.first_y : in_data.disk_radius;
		dx2 = 16'(dmx) * 16'(dmx);
		dy2 = 16'(dmy) * 16'(dmy);
		rr  = 16'(in_data.disk_radius) * 16'(in_data.disk_radius);

		push_cmd          = '0;
		push_cmd.op       = fde_pkg::OP_NOP;
		push_cmd.value    = in_data.pixel_value;
		push_cmd.cx       = in_data.first_x;
		push_cmd.cy       = in_data.first_y;
		push_cmd.rr       = rr;
		push_cmd.dx2_init = {1'b0, dx2};
		push_cmd.dy2_init = {1'b0, dy2};

		case (in_data.mode)
			fde_pkg::MODE_PIXEL: begin
				if (in1) begin
					push_cmd.op   = fde_pkg::OP_BOX;
					push_cmd.x_lo = in_data.first_x;
					push_cmd.x_hi = in_data.first_x;
					push_cmd.y_lo = in_data.first_y;
					push_cmd.y_hi = in_data.first_y;
				end
			end
			fde_pkg::MODE_FILL: begin
				if (area_ok) begin
					push_cmd.op   = fde_pkg::OP_BOX;
					push_cmd.x_lo = '0;
					push_cmd.x_hi = x_lim;
					push_cmd.y_lo = '0;
					push_cmd.y_hi = y_lim;
				end
			end
			fde_pkg::MODE_LINE: begin
				if (in1 && in2 && axis_ok) begin
					push_cmd.op   = fde_pkg::OP_BOX;
					push_cmd.x_lo = x_min;
					push_cmd.x_hi = x_max;
					push_cmd.y_lo = y_min;
					push_cmd.y_hi = y_max;
				end else begin
					push_cmd.err = 1'b1;
				end
			end
			fde_pkg::MODE_RECT: begin
				if (in1 && in2) begin
					push_cmd.op   = fde_pkg::OP_OUTLINE;
					push_cmd.x_lo = x_min;
					push_cmd.x_hi = x_max;
					push_cmd.y_lo = y_min;
					push_cmd.y_hi = y_max;
				end else begin
					push_cmd.err = 1'b1;
				end
			end
			fde_pkg::MODE_DISK: begin
				if (area_ok && (xs <= x_lim) && (ys <= y_lim)) begin
					push_cmd.op   = fde_pkg::OP_DISK;
					push_cmd.x_lo = xs;
					push_cmd.x_hi = xe;
					push_cmd.y_lo = ys;
					push_cmd.y_hi = ye;
				end
			end
			fde_pkg::MODE_READ: begin
				if (in1) begin
					push_cmd.op   = fde_pkg::OP_READ;
					push_cmd.x_lo = in_data.first_x;
					push_cmd.y_lo = in_data.first_y;
				end
			end
			default: begin
				push_cmd.op = fde_pkg::OP_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/fde_cmd_queue.sv]
// ----------------------------------------------------------------------------
// fde_cmd_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module fde_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fde_pkg::cmd_t  push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output fde_pkg::cmd_t       head_cmd
);

	fde_pkg::cmd_t                slot_q [fde_pkg::QUEUE_DEPTH];
	logic [fde_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [fde_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [fde_pkg::QPTR_W:0]     count_q;

	localparam logic [fde_pkg::QPTR_W-1:0] PTR_LAST = fde_pkg::QPTR_W'(fde_pkg::QUEUE_DEPTH - 1);
	localparam logic [fde_pkg::QPTR_W:0]   CNT_FULL = (fde_pkg::QPTR_W + 1)'(fde_pkg::QUEUE_DEPTH);

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

[sv/fde_back.sv]
// ----------------------------------------------------------------------------
// fde_back
// pixel store, clearing pass, raster walker and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "framebuffer_draw_engine_top_assert.svh"

module fde_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_pop,
	input  wire fde_pkg::cmd_t  q_cmd,
	output logic                clearing,
	output logic                out_valid,
	input  wire logic           out_stall,
	output fde_pkg::result_t    out_data
);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_DRAW   = 5'b00100,
		ST_READ   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [fde_pkg::ADDR_W-1:0]      clr_q;
	logic                            out_valid_q;
	fde_pkg::result_t                out_q;

	fde_pkg::cmd_t                   cmd_q;
	logic [fde_pkg::X_W-1:0]         x_q;
	logic [fde_pkg::Y_W-1:0]         y_q;
	logic [16:0]                     dx2_q;
	logic [16:0]                     dy2_q;

	logic [7:0]                      mem [fde_pkg::FB_DEPTH];
	logic [7:0]                      rdata_q;

	logic                            last_x, last_pix, edge_row, in_disk, out_free, wr_en;
	logic [17:0]                     dsum;
	logic [16:0]                     dx2_step, dy2_step;
	logic [fde_pkg::ADDR_W-1:0]      wr_addr;
	logic [7:0]                      wr_data;

	always_comb begin
		last_x   = (x_q == cmd_q.x_hi);
		last_pix = last_x && (y_q == cmd_q.y_hi);
		edge_row = (y_q == cmd_q.y_lo) || (y_q == cmd_q.y_hi);
		dsum     = {1'b0, dx2_q} + {1'b0, dy2_q};
		in_disk  = (dsum <= {2'b00, cmd_q.rr});
		// (d+1)^2 = d^2 + 2d + 1 with d = pos - center
		dx2_step = 17'(dx2_q + {8'd0, x_q, 1'b1} - {8'd0, cmd_q.cx, 1'b0});
		dy2_step = 17'(dy2_q + {8'd0, y_q, 1'b1} - {8'd0, cmd_q.cy, 1'b0});
		out_free = !out_valid_q || !out_stall;
		q_pop    = (state_q == ST_IDLE) && q_valid;
		clearing = (state_q == ST_CLEAR);
		wr_en    = clearing ||
			((state_q == ST_DRAW) && ((cmd_q.op != fde_pkg::OP_DISK) || in_disk));
		wr_addr  = clearing ? clr_q : {y_q, x_q};
		wr_data  = clearing ? 8'd0 : cmd_q.value;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						case (q_cmd.op)
							fde_pkg::OP_NOP:  state_q <= ST_FINISH;
							fde_pkg::OP_READ: state_q <= ST_READ;
							default:          state_q <= ST_DRAW;
						endcase
					end
				end
				ST_DRAW: begin
					if (last_pix) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			x_q   <= q_cmd.x_lo;
			y_q   <= q_cmd.y_lo;
			dx2_q <= q_cmd.dx2_init;
			dy2_q <= q_cmd.dy2_init;
		end else if (state_q == ST_DRAW && !last_pix) begin
			if (last_x) begin
				x_q   <= cmd_q.x_lo;
				y_q   <= y_q + 1'b1;
				dx2_q <= cmd_q.dx2_init;
				dy2_q <= dy2_step;
			end else if (cmd_q.op == fde_pkg::OP_OUTLINE && !edge_row && x_q == cmd_q.x_lo) begin
				// inner rows of an outline only touch the two side columns
				x_q <= cmd_q.x_hi;
			end else begin
				x_q   <= x_q + 1'b1;
				dx2_q <= dx2_step;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q.read_value  <= (cmd_q.op == fde_pkg::OP_READ) ? rdata_q : 8'd0;
			out_q.coord_error <= cmd_q.err;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[{y_q, x_q}];
	end

	`FDE_ASSERT_IMPL(a_draw_in_box, clk, arst_n, state_q == ST_DRAW, x_q >= cmd_q.x_lo && x_q <= cmd_q.x_hi && y_q >= cmd_q.y_lo && y_q <= cmd_q.y_hi)
	`FDE_ASSERT_NEXT(a_read_then_finish, clk, arst_n, state_q == ST_READ, state_q == ST_FINISH)
	`FDE_ASSERT_NEXT(a_finish_loads_result, clk, arst_n, state_q == ST_FINISH && out_free, out_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

[sv/framebuffer_draw_engine_top.sv]
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_top
// 8-bit grayscale framebuffer with pixel, fill, line, outline, disk and read
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  fde_pkg::cmd_in_t command
//   out      source     out_valid/out_stall fde_pkg::result_t, one per command
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data (active size)
//
// after reset a clearing pass zeroes the store, in_stall high; one pixel per
// cycle through the single store write port; states idle, draw over the
// pixels visited (fill w*h, line its length, outline its perimeter, disk
// its clipped bounding box), finish; read idle, read, finish; rejected
// idle, finish; a two-entry queue lets commands arrive while the back end
// draws; a waiting result stalls only the back end, the queue keeps filling
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_draw_engine_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire fde_pkg::cmd_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output fde_pkg::result_t                    out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fde_pkg::SIZE_W-1:0]     cfg_data
);

	logic          push, q_full, pop, head_valid, clearing;
	fde_pkg::cmd_t push_cmd, head_cmd;

	fde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.clearing  (clearing),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	fde_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	fde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (head_valid),
		.q_pop     (pop),
		.q_cmd     (head_cmd),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
